/* src/fcpa_pkg.sv */
// Shared types, widths and codes for the fixed chunk pool allocator.
// No dependencies; used by fcpa_own and fixed_chunk_pool_allocator.
`default_nettype none

package fcpa_pkg;

  localparam int NUM_CHUNKS_DEF = 1024;

  localparam int ADDR_W     = 33;
  localparam int BASE_W     = 32;
  localparam int SIZE_W     = 17;
  localparam int TALLY_W    = 32;
  localparam int BYTES_W    = 27;
  localparam int FREE_W     = 11;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [SIZE_W-1:0] CHUNK_BYTES_RST = 17'd8;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES = 8'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_OWNED = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic done;
    logic owned;
  } own_res_t;

endpackage

`default_nettype wire

/* src/fcpa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module fcpa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/fcpa_own.sv */
// Ownership check for a released address: region bounds, then a restoring
// divider (one quotient bit per cycle) for the chunk index and boundary test.
// Depends on fcpa_pkg.
`default_nettype none

module fcpa_own #(
  parameter int NumChunks = fcpa_pkg::NUM_CHUNKS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [fcpa_pkg::ADDR_W-1:0]       addr,
  input  wire logic [fcpa_pkg::BASE_W-1:0]       base,
  input  wire logic [fcpa_pkg::SIZE_W-1:0]       size,
  output fcpa_pkg::own_res_t                     res,
  output logic      [$clog2(NumChunks)-1:0]      idx
);
  import fcpa_pkg::*;

  localparam int IdxW = $clog2(NumChunks);
  localparam int LimW = SIZE_W + $clog2(NumChunks + 1);
  localparam int DivW = SIZE_W + IdxW - 1;
  localparam int CntW = $clog2(IdxW + 1);

  typedef enum logic [4:0] {
    OS_IDLE  = 5'b00001,
    OS_LIM   = 5'b00010,
    OS_RANGE = 5'b00100,
    OS_DIV   = 5'b01000,
    OS_DONE  = 5'b10000
  } ostate_t;

  ostate_t              state_r;
  logic [ADDR_W-1:0]    rem_r;
  logic                 bad_r;
  logic [SIZE_W-1:0]    size_r;
  logic [LimW-1:0]      lim_r;
  logic [DivW-1:0]      dsh_r;
  logic [IdxW-1:0]      q_r;
  logic [CntW-1:0]      cnt_r;
  logic [ADDR_W:0]      diff;
  logic                 ge;

  assign diff = {1'b0, addr} - (ADDR_W + 1)'(base);
  assign ge   = {1'b0, rem_r} >= (ADDR_W + 1)'(dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= OS_IDLE;
    end else begin
      unique case (state_r)
        OS_IDLE:  if (start) state_r <= OS_LIM;
        OS_LIM:   state_r <= OS_RANGE;
        OS_RANGE: state_r <= OS_DIV;
        OS_DIV:   if (cnt_r == CntW'(1)) state_r <= OS_DONE;
        OS_DONE:  state_r <= OS_IDLE;
        default:  state_r <= OS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      OS_IDLE: begin
        if (start) begin
          rem_r  <= diff[ADDR_W-1:0];
          bad_r  <= (addr == '0) || (size == '0) || diff[ADDR_W];
          size_r <= size;
        end
      end
      OS_LIM: begin
        lim_r <= LimW'(size_r) * LimW'(NumChunks);
        dsh_r <= DivW'(size_r) << (IdxW - 1);
        q_r   <= '0;
        cnt_r <= CntW'(IdxW);
      end
      OS_RANGE: begin
        if ((ADDR_W + 1)'(rem_r) >= (ADDR_W + 1)'(lim_r)) begin
          bad_r <= 1'b1;
        end
      end
      OS_DIV: begin
        if (ge) begin
          rem_r <= ADDR_W'((ADDR_W + 1)'(rem_r) - (ADDR_W + 1)'(dsh_r));
        end
        q_r   <= IdxW'({q_r, ge});
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - CntW'(1);
      end
      default: begin
      end
    endcase
  end

  assign res.done  = (state_r == OS_DONE);
  assign res.owned = !bad_r && (rem_r == '0);
  assign idx       = q_r;

endmodule

`default_nettype wire

/* src/fixed_chunk_pool_allocator.sv */
// Fixed chunk pool allocator: LIFO free-index stack in RAM, counters, control.
// Depends on fcpa_pkg, fcpa_ram and fcpa_own.
//
// Usage:
//   Requests arrive on in_* (valid/ready): allocate (in_req_type 0) or release
//   of in_release_address (in_req_type 1). Each request yields one result on
//   out_* (valid/ready) with status, granted address and the pool counters.
//   Registers region_base (index 0) and chunk_bytes (index 1) are written on
//   cfg_*; the user must write them only while the block is idle, as the block
//   itself does not enforce it; cfg_ready is always high.
//   One request is in work at a time. Allocate: stack RAM read, index multiply,
//   finish; on an empty pool straight to finish. Release: ownership check by the
//   restoring divider that yields one quotient bit per cycle, then finish.
//   A new request is taken the cycle after the result is loaded into the output
//   register.
//   Reset empties the output, sets all chunks free and clears the counters;
//   the stack RAM needs no clearing pass, entries below the lowest depth ever
//   reached read as their own position.
//   A stalled result holds in the output register; the block finishes the
//   next request and waits until the output register frees up.
`default_nettype none

module fixed_chunk_pool_allocator #(
  parameter int NumChunks = fcpa_pkg::NUM_CHUNKS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_req_type,
  input  wire logic [fcpa_pkg::ADDR_W-1:0]        in_release_address,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [fcpa_pkg::STATUS_W-1:0]      out_status,
  output logic      [fcpa_pkg::ADDR_W-1:0]        out_chunk_address,
  output logic      [fcpa_pkg::FREE_W-1:0]        out_free_left,
  output logic      [fcpa_pkg::TALLY_W-1:0]       out_alloc_tally,
  output logic      [fcpa_pkg::TALLY_W-1:0]       out_release_tally,
  output logic      [fcpa_pkg::BYTES_W-1:0]       out_bytes_used,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [fcpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fcpa_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fcpa_pkg::*;

  localparam int IdxW  = $clog2(NumChunks);
  localparam int DepW  = $clog2(NumChunks + 1);
  localparam int ProdW = IdxW + SIZE_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_READ  = 5'b00100,
    S_MUL   = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [BASE_W-1:0]    base_r;
  logic [SIZE_W-1:0]    size_r;
  logic [DepW-1:0]      depth_r;
  logic [DepW-1:0]      lw_r;
  logic [TALLY_W-1:0]   alloc_cnt_r;
  logic [TALLY_W-1:0]   rel_cnt_r;
  logic [BYTES_W-1:0]   bytes_r;
  logic                 is_alloc_r;
  status_t              code_r;
  logic [IdxW-1:0]      idx_r;
  logic [ProdW-1:0]     prod_r;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [ADDR_W-1:0]    out_addr_r;

  logic                 in_acc;
  logic                 load;
  logic [DepW-1:0]      dep_dec;
  logic [IdxW-1:0]      top_pos;
  logic                 mem_re;
  logic                 mem_we;
  logic [IdxW-1:0]      mem_rdata;
  own_res_t             own_res;
  logic [IdxW-1:0]      own_idx;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign load      = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign dep_dec   = depth_r - DepW'(1);
  assign top_pos   = IdxW'(dep_dec);
  assign mem_re    = in_acc && (in_req_type == REQ_ALLOC) && (depth_r != '0);
  assign mem_we    = load && !is_alloc_r && (code_r == ST_OK);
  assign cfg_ready = 1'b1;

  fcpa_ram #(
    .Width (IdxW),
    .Depth (NumChunks)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (IdxW'(depth_r)),
    .wdata (idx_r),
    .re    (mem_re),
    .raddr (top_pos),
    .rdata (mem_rdata)
  );

  fcpa_own #(
    .NumChunks (NumChunks)
  ) u_own (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc && (in_req_type == REQ_RELEASE)),
    .addr  (in_release_address),
    .base  (base_r),
    .size  (size_r),
    .res   (own_res),
    .idx   (own_idx)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_req_type == REQ_RELEASE) begin
            state_nxt = S_CHECK;
          end else if (depth_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_CHECK: if (own_res.done) state_nxt = S_FIN;
      S_READ:  state_nxt = S_MUL;
      S_MUL:   state_nxt = S_FIN;
      S_FIN:   if (load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      size_r      <= CHUNK_BYTES_RST;
      depth_r     <= DepW'(NumChunks);
      lw_r        <= DepW'(NumChunks);
      alloc_cnt_r <= '0;
      rel_cnt_r   <= '0;
      bytes_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_REGION_BASE: base_r <= cfg_data;
          CFG_CHUNK_BYTES: size_r <= cfg_data[SIZE_W-1:0];
          default: begin
          end
        endcase
      end
      if (load) begin
        out_valid_r <= 1'b1;
        if (code_r == ST_OK) begin
          if (is_alloc_r) begin
            depth_r     <= dep_dec;
            alloc_cnt_r <= alloc_cnt_r + TALLY_W'(1);
            bytes_r     <= bytes_r + BYTES_W'(size_r);
            if (dep_dec < lw_r) begin
              lw_r <= dep_dec;
            end
          end else begin
            depth_r   <= depth_r + DepW'(1);
            rel_cnt_r <= rel_cnt_r + TALLY_W'(1);
            bytes_r   <= bytes_r - BYTES_W'(size_r);
          end
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      is_alloc_r <= (in_req_type == REQ_ALLOC);
      code_r     <= (in_req_type == REQ_ALLOC && depth_r == '0) ? ST_EMPTY : ST_OK;
    end
    if (state_r == S_CHECK && own_res.done) begin
      idx_r <= own_idx;
      if (!own_res.owned) begin
        code_r <= ST_NOT_OWNED;
      end else if (depth_r >= DepW'(NumChunks)) begin
        code_r <= ST_FULL;
      end else begin
        code_r <= ST_OK;
      end
    end
    if (state_r == S_READ) begin
      idx_r <= (dep_dec < lw_r) ? top_pos : mem_rdata;
    end
    if (state_r == S_MUL) begin
      prod_r <= ProdW'(idx_r) * ProdW'(size_r);
    end
    if (load) begin
      out_status_r <= code_r;
      if (is_alloc_r && code_r == ST_OK) begin
        out_addr_r <= ADDR_W'(ADDR_W'(base_r) + ADDR_W'(prod_r));
      end else begin
        out_addr_r <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_chunk_address = out_addr_r;
  assign out_free_left     = FREE_W'(depth_r);
  assign out_alloc_tally   = alloc_cnt_r;
  assign out_release_tally = rel_cnt_r;
  assign out_bytes_used    = bytes_r;

endmodule

`default_nettype wire
